// ----- rtl/pnpe_pkg.sv -----
// ----------------------------------------------------------------------------
// pnpe_pkg
// Shared types, constants and the arctangent table of the nearest-point block.
// ----------------------------------------------------------------------------
package pnpe_pkg;

	localparam int PATH_DEPTH_DEF = 1024;
	localparam int ATAN_STEPS_DEF = 16;
	localparam int PLEN_W         = 11;
	localparam logic [PLEN_W-1:0] PATH_LEN_RESET = 11'd1000;

	localparam int PI_Q13      = 25736;
	localparam int TWO_PI_Q13  = 51472;
	localparam int HALF_PI_Q13 = 12868;

	localparam int POS_W  = 32;
	localparam int HEAD_W = 16;
	localparam int IDX_W  = 10;
	localparam int DIFF_W = 33;
	localparam int ANG_W  = 18;
	localparam int PT_W   = 2 * POS_W + HEAD_W + POS_W;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_LOAD,
		ST_SOLVE
	} state_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} scan_beat_t;

	function automatic logic [15:0] atan_q13(input logic [4:0] i);
		logic [15:0] v;
		case (i)
			5'd0:    v = 16'd6434;
			5'd1:    v = 16'd3798;
			5'd2:    v = 16'd2007;
			5'd3:    v = 16'd1019;
			5'd4:    v = 16'd511;
			5'd5:    v = 16'd256;
			5'd6:    v = 16'd128;
			5'd7:    v = 16'd64;
			5'd8:    v = 16'd32;
			5'd9:    v = 16'd16;
			5'd10:   v = 16'd8;
			5'd11:   v = 16'd4;
			5'd12:   v = 16'd2;
			5'd13:   v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/path_nearest_point_error.sv -----
// ----------------------------------------------------------------------------
// path_nearest_point_error
// Nearest-waypoint cross-track error over a stored reference path.
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    tuser opcode, tdata point and robot fields
// m_*      out  m_tvalid/m_tready    tdata error, curvature, heading, slot
// cfg_*    in   cfg_valid/cfg_ready  cfg_data path_length
//
// A load beat is one RAM write. A query makes one RAM read per slot over the
// scanned length through a four-stage distance pipe, one re-read of the
// winner, then 32 square-root steps, with the CORDIC running alongside.
// Reset clears control; the path store is not cleared.
// A pending result in the output register does not block a new beat.
// ----------------------------------------------------------------------------
module path_nearest_point_error #(
	parameter int PATH_DEPTH = pnpe_pkg::PATH_DEPTH_DEF,
	parameter int ATAN_STEPS = pnpe_pkg::ATAN_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// point_index, point_x, point_y, point_heading, point_curvature, robot_x, robot_y
	input  logic [191:0]                s_tdata,
	// opcode
	input  logic                        s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// cross_error, near_curvature, near_heading, nearest_index
	output logic [95:0]                 m_tdata,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pnpe_pkg::PLEN_W-1:0] cfg_data
);
	import pnpe_pkg::*;

	localparam int AW  = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
	localparam int AGW = ANG_W + 1;
	localparam logic signed [AGW-1:0] PI_A  = AGW'(PI_Q13);
	localparam logic signed [AGW-1:0] TPI_A = AGW'(TWO_PI_Q13);

	state_t state_q, state_d;

	logic [PLEN_W-1:0] plen_q;
	logic [AW-1:0]     cnt_q, last_q, slot_q;
	logic signed [POS_W-1:0] rx_q, ry_q;
	logic [POS_W-1:0]  curv_q;
	logic [HEAD_W-1:0] head_q;
	logic              m_tvalid_q;
	logic [95:0]       m_tdata_q;

	logic accept, is_query, idx_ok, ram_we, ram_re, out_free, out_load, start;
	logic [AW-1:0] raddr, best_slot, last_d;
	logic [PT_W-1:0] rdata;
	logic [31:0] plen32, n32;
	scan_beat_t beat;
	logic dist_done, sqrt_done, atan_done;
	logic [POS_W-1:0] root;
	logic signed [ANG_W-1:0] angle;
	logic signed [DIFF_W-1:0] dx, dy;
	logic signed [AGW-1:0] ang, angw;
	logic [POS_W:0] root33;
	logic [POS_W-1:0] err;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign is_query  = (s_tuser == OP_QUERY);
	assign idx_ok    = 32'(s_tdata[9:0]) < PATH_DEPTH;
	assign ram_we    = accept && !is_query && idx_ok;
	assign ram_re    = (state_q == ST_SCAN) || (state_q == ST_FETCH);
	assign raddr     = (state_q == ST_FETCH) ? best_slot : cnt_q;
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		plen32 = 32'(plen_q);
		if (plen32 == 0) begin
			n32 = 32'd1;
		end else if (plen32 > PATH_DEPTH) begin
			n32 = PATH_DEPTH;
		end else begin
			n32 = plen32;
		end
		last_d = AW'(n32 - 32'd1);
	end

	always_comb begin
		beat.valid = (state_q == ST_SCAN);
		beat.first = (cnt_q == '0);
		beat.last  = (cnt_q == last_q);
	end

	always_comb begin
		state_d  = state_q;
		start    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_query) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (beat.last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (dist_done) state_d = ST_FETCH;
			end
			ST_FETCH: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				start   = 1'b1;
				state_d = ST_SOLVE;
			end
			ST_SOLVE: begin
				if (sqrt_done && atan_done && out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			plen_q     <= PATH_LEN_RESET;
			cnt_q      <= '0;
			last_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) plen_q <= cfg_data;
			if (accept && is_query) begin
				cnt_q  <= '0;
				last_q <= last_d;
			end else if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			rx_q <= s_tdata[153:122];
			ry_q <= s_tdata[185:154];
		end
		if (state_q == ST_LOAD) begin
			curv_q <= rdata[111:80];
			head_q <= rdata[79:64];
			slot_q <= best_slot;
		end
		if (out_load) begin
			m_tdata_q <= {6'd0, IDX_W'(slot_q), head_q, curv_q, err};
		end
	end

	pnpe_ram #(.WIDTH(PT_W), .DEPTH(PATH_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(s_tdata[9:0])),
		.wdata (s_tdata[121:10]),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	pnpe_dist #(.AW(AW)) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.beat_idx  (cnt_q),
		.pt_x      (rdata[31:0]),
		.pt_y      (rdata[63:32]),
		.rx        (rx_q),
		.ry        (ry_q),
		.done      (dist_done),
		.best_slot (best_slot)
	);

	logic [2*POS_W-1:0] sq_win;
	logic [POS_W-1:0] adx, ady;
	always_comb begin
		dx  = DIFF_W'($signed(rdata[31:0])) - DIFF_W'(rx_q);
		dy  = DIFF_W'($signed(rdata[63:32])) - DIFF_W'(ry_q);
		adx = dx[DIFF_W-1] ? POS_W'(-dx) : POS_W'(dx);
		ady = dy[DIFF_W-1] ? POS_W'(-dy) : POS_W'(dy);
	end

	// winner's squared distance is rebuilt from the re-read point
	logic [2*POS_W-1:0] sqx_q, sqy_q;
	logic [2*POS_W:0] sqsum;
	logic solve_go_q;
	always_ff @(posedge clk) begin
		if (start) begin
			sqx_q <= adx * adx;
			sqy_q <= ady * ady;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) solve_go_q <= 1'b0;
		else         solve_go_q <= start;
	end
	assign sqsum  = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign sq_win = sqsum[2*POS_W] ? '1 : sqsum[2*POS_W-1:0];

	pnpe_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (solve_go_q),
		.value  (sq_win),
		.done   (sqrt_done),
		.root   (root)
	);

	pnpe_cordic #(.ATAN_STEPS(ATAN_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.dx     (dx),
		.dy     (dy),
		.done   (atan_done),
		.angle  (angle)
	);

	always_comb begin
		ang = AGW'($signed(head_q)) - AGW'(angle);
		if (ang > PI_A) begin
			angw = ang - TPI_A;
		end else if (ang < -PI_A) begin
			angw = ang + TPI_A;
		end else begin
			angw = ang;
		end
		root33 = {1'b0, root};
		if (angw < 0) begin
			err = (root33 > 33'h080000000) ? 32'h80000000 : POS_W'(-root33);
		end else begin
			err = (root33 > 33'h07FFFFFFF) ? 32'h7FFFFFFF : root;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		dist_done |-> state_q == ST_DRAIN)
		else $error("scan finished outside drain");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_tready))
		else $error("result overwrote a pending beat");
	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SOLVE) |-> !s_tready)
		else $error("input taken while solving");
`endif

endmodule

// ----- rtl/pnpe_ram.sv -----
// ----------------------------------------------------------------------------
// pnpe_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pnpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/pnpe_dist.sv -----
// ----------------------------------------------------------------------------
// pnpe_dist
// Squared-distance pipeline and running minimum over the scanned slots.
// ----------------------------------------------------------------------------
module pnpe_dist #(
	parameter int AW = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pnpe_pkg::scan_beat_t              beat,
	input  logic [AW-1:0]                     beat_idx,
	input  logic signed [pnpe_pkg::POS_W-1:0] pt_x,
	input  logic signed [pnpe_pkg::POS_W-1:0] pt_y,
	input  logic signed [pnpe_pkg::POS_W-1:0] rx,
	input  logic signed [pnpe_pkg::POS_W-1:0] ry,
	output logic                              done,
	output logic [AW-1:0]                     best_slot
);
	import pnpe_pkg::*;

	scan_beat_t beat_s1, beat_s2, beat_s3;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3;
	logic [POS_W-1:0] ax_s2, ay_s2;
	logic [2*POS_W-1:0] sqx_s3, sqy_s3;
	logic [2*POS_W-1:0] best_q;
	logic [AW-1:0] best_slot_q;
	logic done_q;

	logic signed [DIFF_W-1:0] dx, dy, adx, ady;
	logic [2*POS_W:0] sum;
	logic [2*POS_W-1:0] dsq;

	always_comb begin
		dx  = DIFF_W'(pt_x) - DIFF_W'(rx);
		dy  = DIFF_W'(pt_y) - DIFF_W'(ry);
		adx = dx[DIFF_W-1] ? -dx : dx;
		ady = dy[DIFF_W-1] ? -dy : dy;
		sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};
		dsq = sum[2*POS_W] ? '1 : sum[2*POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s1     <= '0;
			beat_s2     <= '0;
			beat_s3     <= '0;
			done_q      <= 1'b0;
			best_q      <= '0;
			best_slot_q <= '0;
		end else begin
			beat_s1 <= beat;
			beat_s2 <= beat_s1;
			beat_s3 <= beat_s2;
			done_q  <= beat_s3.valid && beat_s3.last;
			// first slot seeds the minimum; strict compare keeps the earliest tie
			if (beat_s3.valid && (beat_s3.first || dsq < best_q)) begin
				best_q      <= dsq;
				best_slot_q <= idx_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= beat_idx;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		ax_s2  <= adx[POS_W-1:0];
		ay_s2  <= ady[POS_W-1:0];
		sqx_s3 <= ax_s2 * ax_s2;
		sqy_s3 <= ay_s2 * ay_s2;
	end

	assign done      = done_q;
	assign best_slot = best_slot_q;

endmodule

// ----- rtl/pnpe_isqrt.sv -----
// ----------------------------------------------------------------------------
// pnpe_isqrt
// Bit-per-cycle restoring integer square root of a 64-bit value.
// ----------------------------------------------------------------------------
module pnpe_isqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [2*pnpe_pkg::POS_W-1:0] value,
	output logic                     done,
	output logic [pnpe_pkg::POS_W-1:0]   root
);
	import pnpe_pkg::*;

	logic [2*POS_W-1:0] v_q;
	logic [POS_W+1:0]   rem_q;
	logic [POS_W-1:0]   root_q;
	logic [5:0]         cnt_q;
	logic               busy_q, done_q;

	logic [POS_W+1:0] rem_sh, trial;
	logic             take;

	always_comb begin
		rem_sh = {rem_q[POS_W-1:0], v_q[2*POS_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		take   = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(POS_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[2*POS_W-3:0], 2'b00};
			rem_q  <= take ? rem_sh - trial : rem_sh;
			root_q <= {root_q[POS_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- rtl/pnpe_cordic.sv -----
// ----------------------------------------------------------------------------
// pnpe_cordic
// Vectoring CORDIC atan2 with quadrant pre-rotation, one step per cycle.
// ----------------------------------------------------------------------------
module pnpe_cordic #(
	parameter int ATAN_STEPS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [pnpe_pkg::DIFF_W-1:0] dx,
	input  logic signed [pnpe_pkg::DIFF_W-1:0] dy,
	output logic                               done,
	output logic signed [pnpe_pkg::ANG_W-1:0]  angle
);
	import pnpe_pkg::*;

	localparam int CW = DIFF_W + 4;
	localparam int IW = $clog2(ATAN_STEPS + 1);

	logic signed [CW-1:0]    x_q, y_q;
	logic signed [ANG_W-1:0] z_q;
	logic [IW-1:0]           i_q;
	logic                    zero_q, busy_q, done_q;

	logic signed [CW-1:0]    x0, y0, xs, ys;
	logic signed [ANG_W-1:0] z0, at;

	always_comb begin
		x0 = CW'(dx);
		y0 = CW'(dy);
		z0 = '0;
		if (dx < 0) begin
			if (dy >= 0) begin
				x0 = CW'(dy);
				y0 = -CW'(dx);
				z0 = ANG_W'(HALF_PI_Q13);
			end else begin
				x0 = -CW'(dy);
				y0 = CW'(dx);
				z0 = -ANG_W'(HALF_PI_Q13);
			end
		end
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = ANG_W'(atan_q13(5'(i_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (busy_q) begin
			i_q <= i_q + 1'b1;
			if (i_q == IW'(ATAN_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x0;
			y_q    <= y0;
			z_q    <= z0;
			zero_q <= (dx == 0) && (dy == 0);
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign done  = done_q;
	assign angle = zero_q ? '0 : z_q;

endmodule
